>>> hdl/bvop_pkg.sv
package bvop_pkg;

    // Field and register widths
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int POS_W       = 11;
    localparam int MODE_W      = 3;
    localparam int CMPW_W      = 11;
    localparam int SHIFT_W     = 10;
    localparam int OP_W        = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int ONES_W      = 6;

    // Default store depth in words
    localparam int STORE_DEPTH_DEFAULT = 1024;

    // Saturation limits
    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation codes of an input item
    localparam logic [OP_W-1:0] OP_LOAD_X = 2'd0;
    localparam logic [OP_W-1:0] OP_Y_WORD = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_COUNT_Y = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AND     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OR      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROTATE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WINDOW  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_WORDS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT         = 2'd2;

    // How a Y word contributes to the running count
    typedef enum logic [1:0] {
        ADD_NONE,
        ADD_Y,
        ADD_AND,
        ADD_OR
    } add_kind_t;

    // Count of set bits in a 32-bit word, by the usual bit-slice reduction.
    function automatic logic [ONES_W-1:0] ones32(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] v;
        begin
            v = word - ((word >> 1) & 32'h5555_5555);
            v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
            v = (v + (v >> 4)) & 32'h0F0F_0F0F;
            v = v + (v >> 8) + (v >> 16) + (v >> 24);
            return v[ONES_W-1:0];
        end
    endfunction

endpackage

>>> hdl/bitvector_overlap_popcount.sv
// Channel    Handshake                 Payload
// input      in_valid / in_stall       op, data_word, last
// result     out_valid / out_stall     bit_count, range_error
// config     cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is taken in every cycle while in_stall is low. An item is held in the
// lookup stage, where the X store is read through its registered port, and the
// result of a final Y word moves from there into the output register.
// rst_n clears all control state; the X store itself is not cleared and reads as
// zero beyond the loaded length. A stalled result holds the lookup stage only when
// that stage carries the next result; other items keep flowing.
module bitvector_overlap_popcount
#(
    parameter int STORE_DEPTH = bvop_pkg::STORE_DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bvop_pkg::OP_W-1:0]         op,
    input  logic [bvop_pkg::WORD_W-1:0]       data_word,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bvop_pkg::COUNT_W-1:0]      bit_count,
    output logic                              range_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bvop_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bvop_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bvop_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam int WW = ((LW > POS_W) ? LW : POS_W) + 2;

    // Configuration registers
    logic [MODE_W-1:0]  mode_reg;
    logic [CMPW_W-1:0]  compare_words_reg;
    logic [SHIFT_W-1:0] shift_reg;

    // Run state
    logic [LW-1:0]      x_length_reg;
    logic [POS_W-1:0]   y_position_reg;
    logic [COUNT_W-1:0] running_count_reg;

    // X store
    logic [WORD_W-1:0]  x_mem [STORE_DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;

    // Lookup stage
    logic               a_valid_reg;
    logic               a_clear_reg;
    logic               a_last_reg;
    logic               a_err_reg;
    logic               a_hit_reg;
    add_kind_t          a_kind_reg;
    logic [WORD_W-1:0]  a_word_reg;

    // Output register
    logic               out_valid_reg;
    logic [COUNT_W-1:0] bit_count_reg;
    logic               range_error_reg;

    // Combinational signals
    logic               in_accept;
    logic               a_result;
    logic               a_advance;
    logic [WW-1:0]      n_w;
    logic [WW-1:0]      s_w;
    logic [WW-1:0]      p_w;
    logic [WW-1:0]      xl_w;
    logic [WW-1:0]      addr_w;
    logic               use_x;
    logic               hit;
    logic               err;
    add_kind_t          kind;
    logic [WORD_W-1:0]  x_word;
    logic [WORD_W-1:0]  operand;
    logic [ONES_W-1:0]  ones;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] sum_sat;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_AND;
            compare_words_reg <= '0;
            shift_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MODE)
            begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            else if (cfg_index == CFG_COMPARE_WORDS)
            begin
                compare_words_reg <= cfg_data[CMPW_W-1:0];
            end
            else if (cfg_index == CFG_SHIFT)
            begin
                shift_reg <= cfg_data[SHIFT_W-1:0];
            end
        end
    end

    // Address selection for an incoming Y word, by mode.
    always_comb
    begin
        n_w  = (WW'(compare_words_reg) < WW'(STORE_DEPTH)) ? WW'(compare_words_reg)
                                                            : WW'(STORE_DEPTH);
        s_w  = WW'(shift_reg);
        p_w  = WW'(y_position_reg);
        xl_w = WW'(x_length_reg);
        addr_w = p_w;
        use_x  = 1'b0;
        kind   = ADD_Y;
        unique case (mode_reg)
            MODE_AND:
            begin
                use_x = (p_w < n_w);
                kind  = use_x ? ADD_AND : ADD_NONE;
            end
            MODE_OR:
            begin
                use_x = (p_w < n_w);
                kind  = use_x ? ADD_OR : ADD_NONE;
            end
            MODE_ROTATE:
            begin
                addr_w = (p_w < s_w) ? (p_w + n_w - s_w) : (p_w - s_w);
                use_x  = (s_w <= n_w) && ((p_w < s_w) || (p_w < n_w));
                kind   = use_x ? ADD_AND : ADD_NONE;
            end
            MODE_WINDOW:
            begin
                addr_w = s_w + p_w;
                use_x  = (addr_w < xl_w);
                kind   = use_x ? ADD_AND : ADD_NONE;
            end
            default:
            begin
                kind = ADD_Y;
            end
        endcase
        // Entries past the loaded length read as zero.
        hit = use_x && (addr_w < xl_w);
        err = ((mode_reg == MODE_ROTATE) && (s_w > n_w))
           || ((mode_reg == MODE_WINDOW) && ((s_w + p_w + WW'(1)) > xl_w));
    end

    // Handshake of the input side.
    assign a_result  = a_valid_reg && !a_clear_reg && a_last_reg;
    assign a_advance = a_valid_reg && !(a_result && out_valid_reg && out_stall);
    assign in_stall  = a_valid_reg && !a_advance;
    assign in_accept = in_valid && !in_stall;

    // Store length and run position, updated as each item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_length_reg   <= '0;
            y_position_reg <= '0;
        end
        else if (in_accept)
        begin
            if (op == OP_LOAD_X)
            begin
                if (x_length_reg < LW'(STORE_DEPTH))
                begin
                    x_length_reg <= x_length_reg + LW'(1);
                end
            end
            else if (op == OP_CLEAR)
            begin
                x_length_reg   <= '0;
                y_position_reg <= '0;
            end
            else if (op == OP_Y_WORD)
            begin
                if (last)
                begin
                    y_position_reg <= '0;
                end
                else if (y_position_reg != POS_MAX)
                begin
                    y_position_reg <= y_position_reg + POS_W'(1);
                end
            end
        end
    end

    // X store: one write port for loads, one registered read port for Y words.
    always_ff @(posedge clk)
    begin
        if (in_accept && (op == OP_LOAD_X) && (x_length_reg < LW'(STORE_DEPTH)))
        begin
            x_mem[x_length_reg[AW-1:0]] <= data_word;
        end
        if (in_accept && (op == OP_Y_WORD))
        begin
            rd_data_reg <= x_mem[addr_w[AW-1:0]];
        end
    end

    // Lookup stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            a_valid_reg <= (op == OP_Y_WORD) || (op == OP_CLEAR);
        end
        else if (a_advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Lookup stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_clear_reg <= (op == OP_CLEAR);
            a_last_reg  <= last;
            a_err_reg   <= err;
            a_hit_reg   <= hit;
            a_kind_reg  <= kind;
            a_word_reg  <= data_word;
        end
    end

    // Combine X with Y, or take Y alone, by kind, and add its set bits, saturating.
    always_comb
    begin
        x_word = a_hit_reg ? rd_data_reg : '0;
        unique case (a_kind_reg)
            ADD_NONE: operand = '0;
            ADD_Y:    operand = a_word_reg;
            ADD_AND:  operand = x_word & a_word_reg;
            ADD_OR:   operand = x_word | a_word_reg;
            default:  operand = '0;
        endcase
        ones    = ones32(operand);
        sum     = {1'b0, running_count_reg} + (COUNT_W + 1)'(ones);
        sum_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end

    // Running count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_count_reg <= '0;
        end
        else if (a_advance)
        begin
            if (a_clear_reg || a_last_reg)
            begin
                running_count_reg <= '0;
            end
            else
            begin
                running_count_reg <= sum_sat;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_advance && a_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance && a_result)
        begin
            bit_count_reg   <= a_err_reg ? '0 : sum_sat;
            range_error_reg <= a_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bit_count   = bit_count_reg;
    assign range_error = range_error_reg;

endmodule

>>> verif/bitvector_overlap_popcount_checker.sv
`timescale 1ns / 1ps

module bitvector_overlap_popcount_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [bvop_pkg::OP_W-1:0]        op,
    input  logic [bvop_pkg::WORD_W-1:0]      data_word,
    input  logic                             last,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [bvop_pkg::COUNT_W-1:0]     bit_count,
    input  logic                             range_error,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [bvop_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bvop_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               counts_checked,
    output int                               errors_seen
);
    import bvop_pkg::*;

    localparam int DEPTH = STORE_DEPTH_DEFAULT;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               err;
    } overlap_result_t;

    // Shadow copy of the block's vectors, run counters and registers.
    logic [WORD_W-1:0] x_words [DEPTH];
    int unsigned       x_len;
    int unsigned       y_pos;
    int unsigned       run_total;
    logic [MODE_W-1:0] cur_mode;
    logic [CMPW_W-1:0] cur_cmpw;
    logic [SHIFT_W-1:0] cur_shift;

    overlap_result_t expected_counts [$];
    overlap_result_t oldest;
    int fails   = 0;
    int checked = 0;
    int flagged = 0;

    task automatic clear_vectors();
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                x_words[i] = '0;
            end
            x_len     = 0;
            y_pos     = 0;
            run_total = 0;
        end
    endtask

    // Works out what one accepted item does to the shadow state, and queues
    // the count that a final Y word must produce.
    task automatic predict_count(input logic [OP_W-1:0] o, input logic [WORD_W-1:0] w,
                                 input logic l);
        int unsigned     n;
        int unsigned     s;
        int unsigned     p;
        int unsigned     gain;
        logic            err;
        overlap_result_t r;
        begin
            n    = (cur_cmpw < DEPTH) ? cur_cmpw : DEPTH;
            s    = cur_shift;
            p    = y_pos;
            gain = 0;
            if (o == OP_LOAD_X)
            begin
                if (x_len < DEPTH)
                begin
                    x_words[x_len] = w;
                    x_len++;
                end
            end
            else if (o == OP_CLEAR)
            begin
                clear_vectors();
            end
            else if (o == OP_Y_WORD)
            begin
                case (cur_mode)
                    MODE_AND:
                        if (p < n) gain = $countones(x_words[p] & w);
                    MODE_OR:
                        if (p < n) gain = $countones(x_words[p] | w);
                    MODE_ROTATE:
                        if (s <= n)
                        begin
                            // The rotated X wraps round at the compare length.
                            if (p < s) gain = $countones(x_words[p + n - s] & w);
                            else if (p < n) gain = $countones(x_words[p - s] & w);
                        end
                    MODE_WINDOW:
                        if (s + p < x_len) gain = $countones(x_words[s + p] & w);
                    default:
                        gain = $countones(w);
                endcase
                run_total = run_total + gain;
                if (run_total > COUNT_MAX) run_total = COUNT_MAX;
                if (y_pos < POS_MAX) y_pos++;
                if (l)
                begin
                    err = (cur_mode == MODE_ROTATE && s > n) ||
                          (cur_mode == MODE_WINDOW && s + p + 1 > x_len);
                    r.count = err ? '0 : run_total[COUNT_W-1:0];
                    r.err   = err;
                    expected_counts.push_back(r);
                    y_pos     = 0;
                    run_total = 0;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_vectors();
            cur_mode  = MODE_AND;
            cur_cmpw  = '0;
            cur_shift = '0;
            expected_counts.delete();
            pending        <= 0;
            fail_count     <= 0;
            counts_checked <= 0;
            errors_seen    <= 0;
        end
        else
        begin
            // Compare each accepted count with the oldest one outstanding.
            if (out_valid && !out_stall)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("unexpected count item: bit_count %0d, range_error %0b",
                           bit_count, range_error);
                    fails++;
                end
                else
                begin
                    oldest = expected_counts.pop_front();
                    checked++;
                    if (oldest.err) flagged++;
                    if (bit_count !== oldest.count)
                    begin
                        $error("bit_count: expected %0d, got %0d", oldest.count, bit_count);
                        fails++;
                    end
                    if (range_error !== oldest.err)
                    begin
                        $error("range_error: expected %0b, got %0b", oldest.err, range_error);
                        fails++;
                    end
                end
            end

            // The user lands register writes only while idle; not enforced.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:          cur_mode  = cfg_data[MODE_W-1:0];
                    CFG_COMPARE_WORDS: cur_cmpw  = cfg_data[CMPW_W-1:0];
                    CFG_SHIFT:         cur_shift = cfg_data[SHIFT_W-1:0];
                    default:           ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                predict_count(op, data_word, last);
            end

            pending        <= expected_counts.size();
            fail_count     <= fails;
            counts_checked <= checked;
            errors_seen    <= flagged;
        end
    end

endmodule

>>> verif/bitvector_overlap_popcount_tb.sv
`timescale 1ns / 1ps

module bitvector_overlap_popcount_tb;
    import bvop_pkg::*;

    localparam int DEPTH        = STORE_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 150;
    localparam int CALM_ITEMS   = 40;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 600000;

    // Codes the package leaves unnamed.
    localparam logic [OP_W-1:0]        OP_UNUSED     = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0]      MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0]      MODE_SPARE_HI = 3'd7;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [OP_W-1:0]        op          = '0;
    logic [WORD_W-1:0]      data_word   = '0;
    logic                   last        = 1'b0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [COUNT_W-1:0]     bit_count;
    logic                   range_error;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    int fail_count;
    int pending;
    int counts_checked;
    int errors_seen;

    int          n_items   = 0;
    int          n_counted = 0;
    int          n_cfg     = 0;
    int          cmp_len   = 0;
    bit          gaps_on   = 1'b1;
    logic        rx_bursty = 1'b1;
    logic        hold_req  = 1'b0;
    int unsigned cycle_count = 0;

    bitvector_overlap_popcount uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .data_word   (data_word),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bit_count   (bit_count),
        .range_error (range_error),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    bitvector_overlap_popcount_checker count_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .data_word      (data_word),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bit_count      (bit_count),
        .range_error    (range_error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .counts_checked (counts_checked),
        .errors_seen    (errors_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bitvector_overlap_popcount verification failed");
            $finish;
        end
    end

    // Result side: random stall bursts, or one long hold when asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_req  <= 1'b0;
            end
            else if (rx_bursty && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item, perhaps after an idle burst, and holds it until taken.
    task automatic send_item(input logic [OP_W-1:0] o, input logic [WORD_W-1:0] w,
                             input logic l);
        begin
            cfg_valid <= 1'b0;
            if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            in_valid  <= 1'b1;
            op        <= o;
            data_word <= w;
            last      <= l;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            n_items++;
            if (o != OP_UNUSED) n_counted++;
        end
    endtask

    // Leaves valid high so that back-to-back writes stream; the next item or
    // pause lowers it.
    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] v);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= v;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            n_cfg++;
            if (idx == CFG_COMPARE_WORDS) cmp_len = (v > DEPTH) ? DEPTH : v;
        end
    endtask

    // Stops sending until every count is back and the pipeline has emptied.
    task automatic settle();
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // One random phase: new mode, maybe new compare and shift, usually new X,
    // then Y runs sized round the compare length, a little noise mixed in.
    task automatic random_phase();
        logic [CFG_DATA_W-1:0] v;
        int                    runs;
        int                    len;
        int                    n_x;
        int                    roll;
        bit                    leave_open;
        begin
            settle();
            v = CFG_DATA_W'($urandom());
            if ($urandom_range(0, 3) != 0) v[CFG_DATA_W-1:MODE_W] = '0;
            v[MODE_W-1:0] = ($urandom_range(0, 7) == 0) ?
                            MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)) :
                            MODE_W'($urandom_range(MODE_COUNT_Y, MODE_WINDOW));
            write_cfg(CFG_MODE, v);
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 7))
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(DEPTH);
                    2:       v = '1;
                    3:       v = CFG_DATA_W'($urandom());
                    default: v = CFG_DATA_W'($urandom_range(1, 40));
                endcase
                write_cfg(CFG_COMPARE_WORDS, v);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(DEPTH - 1);
                    2:       v = CFG_DATA_W'($urandom_range(0, DEPTH - 1));
                    default: v = CFG_DATA_W'($urandom_range(0, (cmp_len < 40) ? cmp_len : 40));
                endcase
                // The top bit lies above the shift field and must be dropped.
                if ($urandom_range(0, 7) == 0) v[CFG_DATA_W-1] = 1'b1;
                write_cfg(CFG_SHIFT, v);
            end

            if ($urandom_range(0, 2) != 0)
            begin
                send_item(OP_CLEAR, random_word(), 1'($urandom_range(0, 1)));
                n_x = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 48);
                repeat (n_x) send_item(OP_LOAD_X, random_word(), 1'($urandom_range(0, 1)));
            end

            runs       = $urandom_range(1, 6);
            leave_open = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < runs; r++)
            begin
                if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 8);
                else len = cmp_len + int'($urandom_range(0, 4)) - 2;
                if (len < 1) len = 1;
                if (len > 64) len = $urandom_range(40, 64);
                for (int i = 0; i < len; i++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3) send_item(OP_UNUSED, random_word(), 1'($urandom_range(0, 1)));
                    else if (roll < 5) send_item(OP_LOAD_X, random_word(), 1'b0);
                    else if (roll == 5) send_item(OP_CLEAR, random_word(), 1'b0);
                    send_item(OP_Y_WORD, random_word(),
                              (i == len - 1) && !(r == runs - 1 && leave_open));
                end
            end
        end
    endtask

    initial
    begin
        int base;
        int phase;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: AND over zero words, so this count is empty.
        send_item(OP_Y_WORD, '1, 1'b1);
        // An unused op code and a final flag on an X load are both ignored.
        send_item(OP_UNUSED, '1, 1'b1);
        send_item(OP_LOAD_X, '1, 1'b1);
        send_item(OP_LOAD_X, '0, 1'b0);
        // Fill the store; the last two loads land on a full store.
        repeat (DEPTH) send_item(OP_LOAD_X, random_word(), 1'($urandom_range(0, 1)));

        // AND and OR with the compare length at and beyond the store depth.
        settle();
        write_cfg(CFG_COMPARE_WORDS, CFG_DATA_W'(DEPTH));
        send_item(OP_Y_WORD, '1, 1'b0);
        send_item(OP_Y_WORD, 32'hA5A5_5A5A, 1'b1);
        settle();
        write_cfg(CFG_MODE, MODE_OR);
        write_cfg(CFG_COMPARE_WORDS, '1);
        send_item(OP_Y_WORD, '0, 1'b1);

        // Rotation by the largest offset, then an offset past the length,
        // then an offset equal to the length.
        settle();
        write_cfg(CFG_MODE, MODE_ROTATE);
        write_cfg(CFG_COMPARE_WORDS, CFG_DATA_W'(DEPTH));
        write_cfg(CFG_SHIFT, CFG_DATA_W'(DEPTH - 1));
        send_item(OP_Y_WORD, '1, 1'b0);
        send_item(OP_Y_WORD, '1, 1'b1);
        settle();
        write_cfg(CFG_COMPARE_WORDS, 11'd5);
        send_item(OP_Y_WORD, '1, 1'b1);
        settle();
        write_cfg(CFG_SHIFT, 11'd5);
        repeat (2) send_item(OP_Y_WORD, '1, 1'b0);
        send_item(OP_Y_WORD, random_word(), 1'b1);

        // Window at the very end of X: one word fits, two overrun.
        settle();
        write_cfg(CFG_MODE, MODE_WINDOW);
        write_cfg(CFG_SHIFT, CFG_DATA_W'(DEPTH - 1));
        send_item(OP_Y_WORD, '1, 1'b1);
        send_item(OP_Y_WORD, '1, 1'b0);
        send_item(OP_Y_WORD, '1, 1'b1);

        // Unassigned mode, written with junk above the mode field.
        settle();
        write_cfg(CFG_MODE, '1);
        send_item(OP_Y_WORD, random_word(), 1'b1);

        // Mode changed in the middle of a run; the unused register index is
        // written too and must change nothing.
        settle();
        write_cfg(CFG_MODE, MODE_COUNT_Y);
        send_item(OP_Y_WORD, '1, 1'b0);
        settle();
        write_cfg(CFG_MODE, MODE_AND);
        write_cfg(CFG_COMPARE_WORDS, 11'd4);
        write_cfg(CFG_SHIFT, '0);
        write_cfg(CFG_UNUSED, '1);
        send_item(OP_Y_WORD, '1, 1'b1);

        // After a clear the window finds X empty.
        settle();
        write_cfg(CFG_MODE, MODE_WINDOW);
        send_item(OP_CLEAR, '1, 1'b1);
        send_item(OP_Y_WORD, '1, 1'b1);

        // Random phases; the first of them holds the result side off for a
        // long stretch while short runs keep arriving.
        base  = n_counted;
        phase = 0;
        while (n_counted - base < RANDOM_ITEMS)
        begin
            if (n_counted - base >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                gaps_on = 1'b0;
                rx_bursty <= 1'b0;
            end
            if (phase == 0)
            begin
                settle();
                hold_req <= 1'b1;
                repeat (40) send_item(OP_Y_WORD, random_word(), 1'b1);
            end
            else
            begin
                random_phase();
            end
            phase++;
        end

        // Close any open run so that nothing is left half done.
        send_item(OP_Y_WORD, random_word(), 1'b1);
        settle();

        $display("Summary: %0d items in, %0d register writes, all modes and a full store;",
                 n_items, n_cfg);
        $display("%0d counts compared, %0d of them with range_error set.",
                 counts_checked, errors_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("bitvector_overlap_popcount verification clean");
        end
        else
        begin
            $display("bitvector_overlap_popcount verification failed");
        end
        $finish;
    end

endmodule

>>> bitvector_overlap_popcount.f
hdl/bvop_pkg.sv
hdl/bitvector_overlap_popcount.sv
verif/bitvector_overlap_popcount_checker.sv
verif/bitvector_overlap_popcount_tb.sv
